### design/hbmt_pkg.sv
// Package for the heartbeat membership table: codes, widths and the slot record.
// No dependencies; the cell, top level, checker and testbench package import it.
package hbmt_pkg;

    localparam int TableEntriesDef = 32;
    localparam int FanoutDef       = 3;

    localparam logic [7:0]  FAIL_PERIOD_RST    = 8'd5;
    localparam logic [15:0] REMOVE_TIMEOUT_RST = 16'd20;
    localparam logic [31:0] TICK_COUNT_RST     = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [1:0] OP_JOIN_REQ  = 2'd1;
    localparam logic [1:0] OP_JOIN_REP  = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    localparam logic [1:0] KIND_JOIN_REPLY = 2'd0;
    localparam logic [1:0] KIND_HEARTBEAT  = 2'd1;
    localparam logic [1:0] KIND_ADDED      = 2'd2;
    localparam logic [1:0] KIND_REMOVED    = 2'd3;

    localparam logic [1:0] REG_FAIL_PERIOD    = 2'd0;
    localparam logic [1:0] REG_REMOVE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_IS_INTRODUCER  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [15:0] port;
        logic [31:0] heartbeat;
        logic [31:0] seen;
    } slot_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] peer_id;
        logic [15:0] peer_port;
        logic [31:0] peer_heartbeat;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        table_full;
        logic [15:0] target_id;
        logic [15:0] target_port;
        logic [31:0] own_heartbeat;
        logic        last;
    } out_beat_t;

    // Command a cell applies to the slot passing through it.
    typedef struct packed {
        logic        touch;   // compare id/port and refresh on match
        logic        age;     // check timeout and drop stale slot
        logic        insert;  // write the slot if this is the chosen free slot
        logic [15:0] id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] tick;
        logic [15:0] timeout;
    } cell_cmd_t;

    // What a cell reports about the slot it just handled.
    typedef struct packed {
        logic matched;
        logic is_free;
        logic removed;
        logic valid;
    } cell_stat_t;

endpackage

### design/hbmt_stream_if.sv
// Valid/ready channel interface for input and result beats.
// Depends on nothing; payload type is a parameter.
interface hbmt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/hbmt_cell.sv
// One cell of the rotating slot ring: holds one slot, applies a command to it.
// Depends on hbmt_pkg.
module hbmt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 apply,
    input  hbmt_pkg::cell_cmd_t  cmd,
    input  hbmt_pkg::slot_t      slot_in,
    output hbmt_pkg::slot_t      slot_out,
    output hbmt_pkg::cell_stat_t stat
);
    import hbmt_pkg::*;

    slot_t       slot_next;
    logic        valid_reg;
    logic [15:0] id_reg;
    logic [15:0] port_reg;
    logic [31:0] heartbeat_reg;
    logic [31:0] seen_reg;
    logic        match;
    logic        stale;

    assign match = slot_in.valid && slot_in.id == cmd.id && slot_in.port == cmd.port;
    assign stale = slot_in.valid && ((cmd.tick - slot_in.seen) > {16'd0, cmd.timeout});

    always_comb
    begin
        slot_next = slot_in;
        if (apply && cmd.touch && match)
        begin
            slot_next.heartbeat = cmd.hb;
            slot_next.seen      = cmd.tick;
        end
        if (apply && cmd.insert)
        begin
            slot_next.valid     = 1'b1;
            slot_next.id        = cmd.id;
            slot_next.port      = cmd.port;
            slot_next.heartbeat = cmd.hb;
            slot_next.seen      = cmd.tick;
        end
        if (apply && cmd.age && stale)
            slot_next.valid = 1'b0;
    end

    assign stat.matched = match;
    assign stat.is_free = !slot_in.valid;
    assign stat.removed = stale;
    assign stat.valid   = slot_in.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (shift)
            valid_reg <= slot_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            id_reg        <= slot_next.id;
            port_reg      <= slot_next.port;
            heartbeat_reg <= slot_next.heartbeat;
            seen_reg      <= slot_next.seen;
        end
    end

    assign slot_out = {valid_reg, id_reg, port_reg, heartbeat_reg, seen_reg};
endmodule

### design/heartbeat_membership_table_core.sv
// Heartbeat membership table top level: sequencer, config registers, cell ring.
// Depends on hbmt_pkg, hbmt_stream_if and hbmt_cell.
//
// Usage:
//   in_ch takes op, peer_id, peer_port, peer_heartbeat, one item at a time;
//   in_ch.ready is high only while the sequencer is idle.
//   out_ch gives kind, table_full, target_id, target_port, own_heartbeat and
//   last; last marks the final result beat of one input.
//   cfg_we/cfg_index/cfg_data write fail_period, remove_timeout, is_introducer;
//   write only while no item is in flight.
//   Slots sit in a ring of N = TABLE_ENTRIES cells; one pass rotates the ring
//   once, one slot per cycle through the head cell while out_ch does not stall.
//   Heartbeat/join request: a search pass, then an insert pass for a new peer
//   or one table_full beat for a full table, plus the join reply for a join.
//   Tick in group or as introducer: a send pass on ping expiry, an aging pass
//   and a flush of the held beat. Join reply and idle tick return to idle.
//   Results are registered; tick results trail one beat in a holding stage.
//   Reset empties the table, sets tick count to all ones, ping counter to 5.
//   A stalled out_ch freezes the ring during send and aging passes and at the
//   insert slot.
module heartbeat_membership_table_core #(
    parameter int TABLE_ENTRIES = hbmt_pkg::TableEntriesDef,
    parameter int FANOUT        = hbmt_pkg::FanoutDef
) (
    input  logic          clk,
    input  logic          rst_n,
    hbmt_stream_if.sink   in_ch,
    hbmt_stream_if.source out_ch,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import hbmt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(FANOUT + 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_INSERT = 8'b0000_0100,
        ST_FULL   = 8'b0000_1000,
        ST_REPLY  = 8'b0001_0000,
        ST_SEND   = 8'b0010_0000,
        ST_AGE    = 8'b0100_0000,
        ST_FLUSH  = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    fail_period_reg;
    logic [15:0]   remove_timeout_reg;
    logic          is_introducer_reg;
    logic [31:0]   tick_count_reg;
    logic [7:0]    ping_left_reg;
    logic [31:0]   self_hb_reg;
    logic          in_group_reg;
    in_beat_t      item_reg;
    logic [IW-1:0] cnt_reg;
    logic          found_reg;
    logic          have_free_reg;
    logic [IW-1:0] free_pos_reg;
    logic [FW-1:0] sent_reg;
    logic          out_valid_reg;
    out_beat_t     out_reg;
    logic          pend_valid_reg;
    out_beat_t     pend_reg;

    slot_t      ring_out [TABLE_ENTRIES];
    cell_stat_t stat_all [TABLE_ENTRIES];
    slot_t      head_slot;
    cell_stat_t head_stat;
    cell_cmd_t  cmd;
    logic       shift;
    logic       apply;
    logic       emit_out;
    logic       emit_tick;
    out_beat_t  emit_beat;
    out_beat_t  pend_last;
    logic       done_pass;
    logic       accept;
    logic       out_free;
    logic       flush_fire;
    logic       found_now;
    logic       free_now;

    // Cell 0 is the head: it applies the command; others just pass data on.
    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            hbmt_cell u_cell (
                .clk(clk), .rst_n(rst_n), .shift(shift),
                .apply((g == 0) ? apply : 1'b0),
                .cmd(cmd), .slot_in(ring_out[(g + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
                .slot_out(ring_out[g]), .stat(stat_all[g])
            );
        end
    endgenerate

    assign head_slot = ring_out[TABLE_ENTRIES-1];
    assign head_stat = stat_all[0];
    assign done_pass = (cnt_reg == IW'(TABLE_ENTRIES - 1));
    assign found_now = found_reg || head_stat.matched;
    assign free_now  = have_free_reg || head_stat.is_free;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign flush_fire  = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;

    always_comb
    begin
        cmd         = '0;
        cmd.id      = item_reg.peer_id;
        cmd.port    = item_reg.peer_port;
        cmd.hb      = item_reg.peer_heartbeat;
        cmd.tick    = tick_count_reg;
        cmd.timeout = remove_timeout_reg;
        shift       = 1'b0;
        apply       = 1'b0;
        emit_out    = 1'b0;
        emit_tick   = 1'b0;
        emit_beat   = '0;
        emit_beat.own_heartbeat = self_hb_reg;
        emit_beat.target_id     = head_slot.id;
        emit_beat.target_port   = head_slot.port;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.data.op) inside
                        OP_HEARTBEAT, OP_JOIN_REQ: state_next = ST_SEARCH;
                        OP_JOIN_REP: ;
                        OP_TICK:
                        begin
                            if (in_group_reg || is_introducer_reg)
                                state_next = (ping_left_reg == 8'd0) ? ST_SEND : ST_AGE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                cmd.touch = 1'b1;
                shift = 1'b1;
                apply = 1'b1;
                if (done_pass)
                begin
                    if (found_now)
                        state_next = (item_reg.op == OP_JOIN_REQ) ? ST_REPLY : ST_IDLE;
                    else if (free_now)
                        state_next = ST_INSERT;
                    else
                        state_next = ST_FULL;
                end
            end
            ST_INSERT:
            begin
                // Rotate once more; write the free slot as it passes the head.
                if (cnt_reg != free_pos_reg || out_free)
                begin
                    shift = 1'b1;
                    if (cnt_reg == free_pos_reg)
                    begin
                        apply = 1'b1;
                        cmd.insert = 1'b1;
                        emit_out = 1'b1;
                        emit_beat.kind        = KIND_ADDED;
                        emit_beat.target_id   = item_reg.peer_id;
                        emit_beat.target_port = item_reg.peer_port;
                        emit_beat.last        = (item_reg.op != OP_JOIN_REQ);
                    end
                    if (done_pass)
                        state_next = (item_reg.op == OP_JOIN_REQ) ? ST_REPLY : ST_IDLE;
                end
            end
            ST_FULL:
            begin
                if (out_free)
                begin
                    emit_out = 1'b1;
                    emit_beat.kind        = KIND_ADDED;
                    emit_beat.table_full  = 1'b1;
                    emit_beat.target_id   = item_reg.peer_id;
                    emit_beat.target_port = item_reg.peer_port;
                    emit_beat.last        = (item_reg.op != OP_JOIN_REQ);
                    state_next = (item_reg.op == OP_JOIN_REQ) ? ST_REPLY : ST_IDLE;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    emit_out = 1'b1;
                    emit_beat.kind        = KIND_JOIN_REPLY;
                    emit_beat.target_id   = item_reg.peer_id;
                    emit_beat.target_port = item_reg.peer_port;
                    emit_beat.last        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    shift = 1'b1;
                    if (head_slot.valid && sent_reg != FW'(FANOUT))
                    begin
                        emit_tick = 1'b1;
                        emit_beat.kind = KIND_HEARTBEAT;
                    end
                    if (done_pass)
                        state_next = ST_AGE;
                end
            end
            ST_AGE:
            begin
                if (out_free)
                begin
                    shift = 1'b1;
                    apply = 1'b1;
                    cmd.age = 1'b1;
                    if (head_stat.removed)
                    begin
                        emit_tick = 1'b1;
                        emit_beat.kind = KIND_REMOVED;
                    end
                    if (done_pass)
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pend_last      = pend_reg;
        pend_last.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            fail_period_reg    <= FAIL_PERIOD_RST;
            remove_timeout_reg <= REMOVE_TIMEOUT_RST;
            is_introducer_reg  <= 1'b0;
            tick_count_reg     <= TICK_COUNT_RST;
            ping_left_reg      <= FAIL_PERIOD_RST;
            self_hb_reg        <= '0;
            in_group_reg       <= 1'b0;
            item_reg           <= '0;
            cnt_reg            <= '0;
            found_reg          <= 1'b0;
            have_free_reg      <= 1'b0;
            free_pos_reg       <= '0;
            sent_reg           <= '0;
            out_valid_reg      <= 1'b0;
            out_reg            <= '0;
            pend_valid_reg     <= 1'b0;
            pend_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FAIL_PERIOD:    fail_period_reg    <= cfg_data[7:0];
                    REG_REMOVE_TIMEOUT: remove_timeout_reg <= cfg_data;
                    REG_IS_INTRODUCER:  is_introducer_reg  <= cfg_data[0];
                    default: ;
                endcase
            end

            if (shift)
                cnt_reg <= done_pass ? '0 : cnt_reg + IW'(1);

            if (accept)
            begin
                found_reg     <= 1'b0;
                have_free_reg <= 1'b0;
            end
            else if (state_reg == ST_SEARCH)
            begin
                if (head_stat.matched)
                    found_reg <= 1'b1;
                if (head_stat.is_free && !have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                    free_pos_reg  <= cnt_reg;
                end
            end

            if (accept)
                sent_reg <= '0;
            else if (state_reg == ST_SEND && emit_tick)
                sent_reg <= sent_reg + FW'(1);

            // Advance the tick count once the aging pass has covered every slot.
            if (state_reg == ST_AGE && shift && done_pass)
                tick_count_reg <= tick_count_reg + 32'd1;

            if (accept)
            begin
                item_reg <= in_ch.data;
                unique case (in_ch.data.op) inside
                    OP_HEARTBEAT, OP_JOIN_REQ: ;
                    OP_JOIN_REP: in_group_reg <= 1'b1;
                    OP_TICK:
                    begin
                        if (in_group_reg || is_introducer_reg)
                        begin
                            if (ping_left_reg == 8'd0)
                            begin
                                ping_left_reg <= fail_period_reg;
                                self_hb_reg   <= self_hb_reg + 32'd1;
                            end
                            else
                                ping_left_reg <= ping_left_reg - 8'd1;
                        end
                    end
                endcase
            end

            // Tick beats wait in the holding stage until the next one shows up,
            // so the final one can be marked last at flush.
            if (emit_out)
            begin
                out_reg       <= emit_beat;
                out_valid_reg <= 1'b1;
            end
            else if (flush_fire)
            begin
                out_reg       <= pend_last;
                out_valid_reg <= 1'b1;
            end
            else if (emit_tick && pend_valid_reg)
            begin
                out_reg       <= pend_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (emit_tick)
            begin
                pend_reg       <= emit_beat;
                pend_valid_reg <= 1'b1;
            end
            else if (flush_fire)
                pend_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
endmodule

### design/hbmt_checker.sv
// Port-level checker for the heartbeat membership table, bound to the top.
// Depends on hbmt_pkg and heartbeat_membership_table_core.
module hbmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic        out_full
);
    import hbmt_pkg::*;

    a_full_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_full |-> out_kind == KIND_ADDED)
        else $error("table_full on a result that is not member added");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_full))
        else $error("result beat changed while stalled");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}) && (in_valid || !in_valid))
        else $error("handshake signal unknown after reset");
endmodule

bind heartbeat_membership_table_core hbmt_checker u_hbmt_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.data.kind), .out_full(out_ch.data.table_full)
);

### tb/hbmt_tb_pkg.sv
// Shared helper types for the membership table testbench.
// Depends on hbmt_pkg for the op, kind and register codes.
package hbmt_tb_pkg;
    import hbmt_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic        table_full;
        logic [15:0] target_id;
        logic [15:0] target_port;
        logic [31:0] own_heartbeat;
        logic        last;
    } event_t;
endpackage

### tb/testbench.sv
// Testbench for heartbeat_membership_table_core: directed and random peer traffic,
// checked beat by beat against an in-bench membership table predictor.
// Depends on hbmt_pkg, hbmt_stream_if, hbmt_tb_pkg and heartbeat_membership_table_core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hbmt_pkg::*;
    import hbmt_tb_pkg::*;

    localparam int ENTRIES = TableEntriesDef;
    localparam int FAN = FanoutDef;
    localparam int STALL_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_index = REG_FAIL_PERIOD;
    logic [15:0] cfg_data = '0;

    hbmt_stream_if #(.T(in_beat_t)) in_ch ();
    hbmt_stream_if #(.T(out_beat_t)) out_ch ();

    heartbeat_membership_table_core uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [7:0]  m_fail_period = FAIL_PERIOD_RST;
    logic [15:0] m_timeout = REMOVE_TIMEOUT_RST;
    logic        m_introducer = 0;
    logic        m_valid [ENTRIES];
    logic [15:0] m_id [ENTRIES];
    logic [15:0] m_port [ENTRIES];
    logic [31:0] m_hb [ENTRIES];
    logic [31:0] m_seen [ENTRIES];
    logic [31:0] m_tick = TICK_COUNT_RST;
    logic [7:0]  m_ping = FAIL_PERIOD_RST;
    logic [31:0] m_self_hb = 0;
    logic        m_in_group = 0;

    event_t pending_events[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int idle_cycles = 0;
    int n_added = 0, n_full = 0, n_removed = 0, n_sent = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) m_valid[i] = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    function automatic void push_event(logic [1:0] k, logic f, logic [15:0] id,
                                       logic [15:0] port);
        event_t e;
        e.kind = k;
        e.table_full = f;
        e.target_id = id;
        e.target_port = port;
        e.own_heartbeat = m_self_hb;
        e.last = 0;
        pending_events.push_back(e);
    endfunction

    function automatic void touch_peer(logic [15:0] id, logic [15:0] port, logic [31:0] hb);
        int free_idx;
        free_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (m_valid[i]) begin
                if (m_id[i] == id && m_port[i] == port) begin
                    m_hb[i] = hb;
                    m_seen[i] = m_tick;
                    return;
                end
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (free_idx < 0) begin
            push_event(KIND_ADDED, 1'b1, id, port);
            return;
        end
        m_valid[free_idx] = 1;
        m_id[free_idx] = id;
        m_port[free_idx] = port;
        m_hb[free_idx] = hb;
        m_seen[free_idx] = m_tick;
        push_event(KIND_ADDED, 1'b0, id, port);
    endfunction

    function automatic void predict_membership(in_beat_t b);
        int prior, sent;
        prior = pending_events.size();
        if (b.op == OP_HEARTBEAT) begin
            touch_peer(b.peer_id, b.peer_port, b.peer_heartbeat);
        end else if (b.op == OP_JOIN_REQ) begin
            touch_peer(b.peer_id, b.peer_port, b.peer_heartbeat);
            push_event(KIND_JOIN_REPLY, 1'b0, b.peer_id, b.peer_port);
        end else if (b.op == OP_JOIN_REP) begin
            m_in_group = 1;
        end else if (m_in_group || m_introducer) begin
            if (m_ping == 0) begin
                sent = 0;
                m_self_hb++;
                for (int i = 0; i < ENTRIES && sent < FAN; i++) begin
                    if (m_valid[i]) begin
                        push_event(KIND_HEARTBEAT, 1'b0, m_id[i], m_port[i]);
                        sent++;
                    end
                end
                m_ping = m_fail_period;
            end else begin
                m_ping--;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (m_valid[i] && (m_tick - m_seen[i]) > {16'd0, m_timeout}) begin
                    push_event(KIND_REMOVED, 1'b0, m_id[i], m_port[i]);
                    m_valid[i] = 0;
                end
            end
            m_tick++;
        end
        if (pending_events.size() > prior)
            pending_events[$].last = 1;
    endfunction

    // receiver: stall pattern, check each accepted beat
    int stall_phase = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            stall_phase <= stall_phase + 1;
            out_ch.ready <= ((stall_phase / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk) begin
        event_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            beats_out++;
            if (pending_events.size() == 0) begin
                $error("result beat with nothing expected: kind %0d", out_ch.data.kind);
                errors++;
            end else begin
                e = pending_events.pop_front();
                case (e.kind)
                    KIND_ADDED: if (e.table_full) n_full++; else n_added++;
                    KIND_REMOVED: n_removed++;
                    KIND_HEARTBEAT: n_sent++;
                    default: ;
                endcase
                if (out_ch.data.kind !== e.kind) begin
                    $error("kind: expected %0d got %0d", e.kind, out_ch.data.kind);
                    errors++;
                end
                if (out_ch.data.table_full !== e.table_full) begin
                    $error("table_full: expected %0d got %0d", e.table_full,
                           out_ch.data.table_full);
                    errors++;
                end
                if (out_ch.data.target_id !== e.target_id) begin
                    $error("target_id: expected %h got %h", e.target_id, out_ch.data.target_id);
                    errors++;
                end
                if (out_ch.data.target_port !== e.target_port) begin
                    $error("target_port: expected %h got %h", e.target_port,
                           out_ch.data.target_port);
                    errors++;
                end
                if (out_ch.data.own_heartbeat !== e.own_heartbeat) begin
                    $error("own_heartbeat: expected %h got %h", e.own_heartbeat,
                           out_ch.data.own_heartbeat);
                    errors++;
                end
                if (out_ch.data.last !== e.last) begin
                    $error("last: expected %0d got %0d", e.last, out_ch.data.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    int burst_left = 0;

    // Hold valid across a burst; drop it only for a gap or a drain.
    task automatic send_beat(logic [1:0] op, logic [15:0] id, logic [15:0] port,
                             logic [31:0] hb);
        in_beat_t b;
        int gap;
        b.op = op;
        b.peer_id = id;
        b.peer_port = port;
        b.peer_heartbeat = hb;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid <= 1;
        in_ch.data <= b;
        do @(posedge clk); while (!in_ch.ready);
        predict_membership(b);
        beats_in++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (2 * ENTRIES + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        drain_results();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_FAIL_PERIOD: m_fail_period = value[7:0];
            REG_REMOVE_TIMEOUT: m_timeout = value;
            REG_IS_INTRODUCER: m_introducer = value[0];
            default: ;
        endcase
    endtask

    task automatic test_directed();
        // ticks before joining do nothing
        send_beat(OP_TICK, 16'h0, 16'h0, 32'h0);
        send_beat(OP_HEARTBEAT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(OP_JOIN_REQ, 16'h0000, 16'h0000, 32'h0);
        send_beat(OP_HEARTBEAT, 16'hFFFF, 16'hFFFF, 32'h5555_AAAA);  // refresh
        send_beat(OP_JOIN_REQ, 16'hFFFF, 16'h0001, 32'h1);
        send_beat(OP_JOIN_REP, 16'h1234, 16'h5678, 32'h0);
        repeat (7) send_beat(OP_TICK, 16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic test_full_table();
        write_reg(REG_REMOVE_TIMEOUT, 16'hFFFF);
        for (int i = 0; i < ENTRIES + 2; i++)
            send_beat(OP_HEARTBEAT, 16'h100 + i[15:0], 16'h2000, $urandom);
        send_beat(OP_JOIN_REQ, 16'hBEEF, 16'hCAFE, 32'h0);  // full, reply still sent
        send_beat(OP_TICK, 16'h0, 16'h0, 32'h0);
    endtask

    task automatic test_aging();
        // quick expiry and removal of the whole table
        write_reg(REG_FAIL_PERIOD, 16'd0);
        write_reg(REG_REMOVE_TIMEOUT, 16'd0);
        repeat (4) send_beat(OP_TICK, 16'h0, 16'h0, 32'h0);
        write_reg(REG_FAIL_PERIOD, 16'hFFFF);
        write_reg(REG_REMOVE_TIMEOUT, 16'd3);
    endtask

    task automatic test_random(int count, logic intro);
        logic [1:0] op;
        write_reg(REG_IS_INTRODUCER, {15'd0, intro});
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: op = OP_HEARTBEAT;
                3, 4:    op = OP_JOIN_REQ;
                5:       op = OP_JOIN_REP;
                default: op = OP_TICK;
            endcase
            // small id pool so refreshes happen, with occasional full-range ids
            if ($urandom_range(0, 4) == 0)
                send_beat(op, 16'($urandom), 16'($urandom), $urandom);
            else
                send_beat(op, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 1)),
                          $urandom);
            if (n == count / 2) drain_results();
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_aging();
        test_random(130, 1'b0);
        write_reg(REG_FAIL_PERIOD, 16'd2);
        write_reg(REG_REMOVE_TIMEOUT, 16'd40);
        test_random(140, 1'b1);
        write_reg(REG_FAIL_PERIOD, 16'd1);
        write_reg(REG_REMOVE_TIMEOUT, 16'd10);
        test_random(100, 1'b0);
        drain_results();
        $display("Covered %0d input beats and %0d result beats.", beats_in, beats_out);
        $display("Adds %0d, full-table rejects %0d, removals %0d, heartbeat sends %0d.",
                 n_added, n_full, n_removed, n_sent);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
design/hbmt_pkg.sv
design/hbmt_stream_if.sv
design/hbmt_cell.sv
design/heartbeat_membership_table_core.sv
design/hbmt_checker.sv
tb/hbmt_tb_pkg.sv
tb/testbench.sv
